// ===== hw/rtl/quad_x_motor_mixer_macros.svh =====
// Assertion macros for the four-motor mixer.
// Included by quad_x_motor_mixer.sv; expects aclk and aresetn in scope.
`ifndef QUAD_X_MOTOR_MIXER_MACROS_SVH
`define QUAD_X_MOTOR_MIXER_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent
`define QXMM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define QXMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QXMM_ASSERT_SAME(label, ante, cons, msg)
`define QXMM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/qxmm_pkg.sv =====
// Shared types, constants and helpers for the four-motor mixer.
// No dependencies; used by quad_x_motor_mixer.
package qxmm_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_USE_VOLTAGE_MODE = 3'd0,
        CFG_MOTORS_ON        = 3'd1,
        CFG_THRUST_GAIN      = 3'd2,
        CFG_ROLL_PITCH_GAIN  = 3'd3,
        CFG_YAW_GAIN         = 3'd4,
        CFG_PWM_MIN          = 3'd5,
        CFG_PWM_MAX          = 3'd6
    } qxmm_cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned GAIN_W     = 24;

    localparam logic [7:0] PWM_MIN_RESET = 8'd20;
    localparam logic [7:0] PWM_MAX_RESET = 8'd255;

    // Motor counted as spinning above this frequency (Hz)
    localparam logic [15:0] SPEED_THRESHOLD = 16'd50;

    // mV * 255 * 256 / 14800 reduces to mV * 816 / 185; /185 done by reciprocal
    localparam int unsigned VOLT_PROD_W     = 26;
    localparam int unsigned VOLT_RECIP_W    = 27;
    localparam int unsigned VOLT_SHIFT      = 34;
    localparam int unsigned VOLT_Q_W        = 19;
    localparam logic [VOLT_RECIP_W-1:0] VOLT_RECIP = 27'd92864158;

    // Load ratio: max / 255 by reciprocal, saturated at 4095
    localparam int unsigned LOAD_IN_W    = 20;
    localparam int unsigned LOAD_RECIP_W = 21;
    localparam int unsigned LOAD_SHIFT   = 28;
    localparam logic [LOAD_RECIP_W-1:0] LOAD_RECIP = 21'd1052689;
    localparam logic signed [23:0] LOAD_SAT_LIMIT = 24'sd1044480;
    localparam logic [11:0] LOAD_SAT = 12'hFFF;

    // Input transaction
    typedef struct packed {
        logic signed [31:0] thrust;
        logic signed [31:0] roll_torque;
        logic signed [31:0] pitch_torque;
        logic signed [31:0] yaw_torque;
        logic [15:0]        voltage_0;
        logic [15:0]        voltage_1;
        logic [15:0]        voltage_2;
        logic [15:0]        voltage_3;
        logic [15:0]        speed_0;
        logic [15:0]        speed_1;
        logic [15:0]        speed_2;
        logic [15:0]        speed_3;
    } qxmm_in_t;

    // Result transaction
    typedef struct packed {
        logic [7:0]  pwm_0;
        logic [7:0]  pwm_1;
        logic [7:0]  pwm_2;
        logic [7:0]  pwm_3;
        logic [11:0] load_ratio;
        logic        overload;
        logic        running;
    } qxmm_out_t;

    // Saturate a floored Q.8 sum to the signed 24-bit range
    function automatic logic signed [23:0] sat_q8(input logic signed [34:0] v);
        logic signed [23:0] r;
        if (v > 35'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -35'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // mV * 816 as shifts and adds (816 = 512 + 256 + 32 + 16)
    function automatic logic [VOLT_PROD_W-1:0] volt_scale(input logic [15:0] mv);
        logic [VOLT_PROD_W-1:0] x;
        x = {1'b0, mv, 9'b0} + {2'b0, mv, 8'b0} + {5'b0, mv, 5'b0} + {6'b0, mv, 4'b0};
        return x;
    endfunction

endpackage

// ===== hw/rtl/quad_x_motor_mixer.sv =====
// Four-motor plus-frame mixer with common-mode desaturation: top level.
// Depends on qxmm_pkg and quad_x_motor_mixer_macros.svh.
//
// Takes one transaction per cycle while the result side does not stall; each
// is registered in the first stage and then in the result register. The
// first register stage holds the four gain products, the four scaled motor
// voltages and the speed check (one 32x25 multiplier per wrench axis, one
// reciprocal multiplier per voltage); the second forms the mix, max/min,
// common shift, clamp and load ratio and updates the sticky running flag.
// The first stage refills whenever it is empty or its content moves on, and
// the second stage moves whenever the result register is empty or read, so
// throughput is one transaction per cycle while results are read.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and takes
// effect immediately; indexes beyond the register list are ignored.
`include "quad_x_motor_mixer_macros.svh"

module quad_x_motor_mixer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [qxmm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qxmm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  qxmm_pkg::qxmm_in_t                    s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output qxmm_pkg::qxmm_out_t                   m_payload
);
    import qxmm_pkg::*;

    // Configuration registers
    logic              use_voltage_mode_reg;
    logic              motors_on_reg;
    logic [GAIN_W-1:0] thrust_gain_reg;
    logic [GAIN_W-1:0] roll_pitch_gain_reg;
    logic [GAIN_W-1:0] yaw_gain_reg;
    logic [7:0]        pwm_min_reg;
    logic [7:0]        pwm_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_voltage_mode_reg <= 1'b0;
            motors_on_reg        <= 1'b0;
            thrust_gain_reg      <= '0;
            roll_pitch_gain_reg  <= '0;
            yaw_gain_reg         <= '0;
            pwm_min_reg          <= PWM_MIN_RESET;
            pwm_max_reg          <= PWM_MAX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_USE_VOLTAGE_MODE: use_voltage_mode_reg <= cfg_wdata[0];
                CFG_MOTORS_ON:        motors_on_reg        <= cfg_wdata[0];
                CFG_THRUST_GAIN:      thrust_gain_reg      <= cfg_wdata[GAIN_W-1:0];
                CFG_ROLL_PITCH_GAIN:  roll_pitch_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_YAW_GAIN:         yaw_gain_reg         <= cfg_wdata[GAIN_W-1:0];
                CFG_PWM_MIN:          pwm_min_reg          <= cfg_wdata[7:0];
                CFG_PWM_MAX:          pwm_max_reg          <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline handshake: stage 2 moves when the result slot is empty or read; stage 1 also refills when empty
    logic v1_reg;
    logic m_valid_reg;
    logic adv2;
    logic load1;
    logic load2;

    assign adv2    = !m_valid_reg || m_ready;
    assign s_ready = !v1_reg || adv2;
    assign load1   = s_valid && s_ready;
    assign load2   = v1_reg && adv2;
    assign m_valid = m_valid_reg;

    // Stage 1: gain products, scaled voltages, speed check
    logic signed [56:0] prod_t;
    logic signed [56:0] prod_r;
    logic signed [56:0] prod_p;
    logic signed [56:0] prod_y;
    logic [15:0]        volt_in [4];
    logic [15:0]        speed_in [4];
    logic [52:0]        volt_mul [4];
    logic [VOLT_Q_W-1:0] volt_q [4];
    logic               all_fast;

    assign prod_t = s_payload.thrust       * $signed({1'b0, thrust_gain_reg});
    assign prod_r = s_payload.roll_torque  * $signed({1'b0, roll_pitch_gain_reg});
    assign prod_p = s_payload.pitch_torque * $signed({1'b0, roll_pitch_gain_reg});
    assign prod_y = s_payload.yaw_torque   * $signed({1'b0, yaw_gain_reg});

    assign volt_in[0]  = s_payload.voltage_0;
    assign volt_in[1]  = s_payload.voltage_1;
    assign volt_in[2]  = s_payload.voltage_2;
    assign volt_in[3]  = s_payload.voltage_3;
    assign speed_in[0] = s_payload.speed_0;
    assign speed_in[1] = s_payload.speed_1;
    assign speed_in[2] = s_payload.speed_2;
    assign speed_in[3] = s_payload.speed_3;

    always_comb begin
        all_fast = 1'b1;
        for (int i = 0; i < 4; i++) begin
            volt_mul[i] = 53'(volt_scale(volt_in[i])) * 53'(VOLT_RECIP);
            volt_q[i]   = volt_mul[i][VOLT_SHIFT +: VOLT_Q_W];
            if (speed_in[i] <= SPEED_THRESHOLD) begin
                all_fast = 1'b0;
            end
        end
    end

    logic signed [56:0]  t_reg;
    logic signed [56:0]  r_reg;
    logic signed [56:0]  p_reg;
    logic signed [56:0]  y_reg;
    logic [VOLT_Q_W-1:0] vq_reg [4];
    logic                fast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    // Hold the stage payload unless a new transaction arrives
    always_ff @(posedge aclk) begin
        if (load1) begin
            t_reg    <= prod_t;
            r_reg    <= prod_r;
            p_reg    <= prod_p;
            y_reg    <= prod_y;
            fast_reg <= all_fast;
            for (int i = 0; i < 4; i++) begin
                vq_reg[i] <= volt_q[i];
            end
        end
    end

    // Stage 2: mix the wrench and floor to Q.8, or take the scaled voltage in voltage mode
    logic signed [58:0] t_e;
    logic signed [58:0] r_e;
    logic signed [58:0] p_e;
    logic signed [58:0] y_e;
    logic signed [58:0] sum [4];
    logic signed [23:0] mix [4];

    assign t_e = $signed({{2{t_reg[56]}}, t_reg});
    assign r_e = $signed({{2{r_reg[56]}}, r_reg});
    assign p_e = $signed({{2{p_reg[56]}}, p_reg});
    assign y_e = $signed({{2{y_reg[56]}}, y_reg});

    assign sum[0] = t_e - p_e + y_e;
    assign sum[1] = t_e - r_e - y_e;
    assign sum[2] = t_e + p_e + y_e;
    assign sum[3] = t_e + r_e - y_e;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (use_voltage_mode_reg) begin
                mix[i] = $signed({{(24-VOLT_Q_W){1'b0}}, vq_reg[i]});
            end else begin
                mix[i] = sat_q8(sum[i][58:24]);
            end
        end
    end

    // Largest and smallest of the four
    logic signed [23:0] mx01;
    logic signed [23:0] mx23;
    logic signed [23:0] mn01;
    logic signed [23:0] mn23;
    logic signed [23:0] mx;
    logic signed [23:0] mn;

    assign mx01 = (mix[1] > mix[0]) ? mix[1] : mix[0];
    assign mx23 = (mix[3] > mix[2]) ? mix[3] : mix[2];
    assign mn01 = (mix[1] < mix[0]) ? mix[1] : mix[0];
    assign mn23 = (mix[3] < mix[2]) ? mix[3] : mix[2];
    assign mx   = (mx23 > mx01) ? mx23 : mx01;
    assign mn   = (mn23 < mn01) ? mn23 : mn01;

    // Load ratio: max / 255, zero below zero, saturated
    logic [40:0] load_mul;
    logic [11:0] load_ratio;

    assign load_mul = 41'(mx[LOAD_IN_W-1:0]) * 41'(LOAD_RECIP);

    always_comb begin
        priority if (mx < 0) begin
            load_ratio = '0;
        end else if (mx >= LOAD_SAT_LIMIT) begin
            load_ratio = LOAD_SAT;
        end else begin
            load_ratio = load_mul[LOAD_SHIFT +: 12];
        end
    end

    // Common shift: lower on overload, else lift to the minimum
    logic signed [25:0] lo_q8;
    logic signed [25:0] hi_q8;
    logic signed [25:0] mx_e;
    logic signed [25:0] mn_e;
    logic signed [25:0] shift_amt;
    logic               over;

    assign lo_q8 = $signed({10'b0, pwm_min_reg, 8'b0});
    assign hi_q8 = $signed({10'b0, pwm_max_reg, 8'b0});
    assign mx_e  = $signed({{2{mx[23]}}, mx});
    assign mn_e  = $signed({{2{mn[23]}}, mn});

    always_comb begin
        over      = 1'b0;
        shift_amt = '0;
        priority if (mx_e > hi_q8) begin
            shift_amt = mx_e - hi_q8;
            over      = 1'b1;
        end else if (mn_e < lo_q8) begin
            shift_amt = mn_e - lo_q8;
        end else begin
            shift_amt = '0;
        end
    end

    // Shift, clamp (lower bound first) and drop the fraction; zero while motors are off
    logic signed [25:0] adj [4];
    logic [7:0]         pwm [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            adj[i] = $signed({{2{mix[i][23]}}, mix[i]}) - shift_amt;
            if (adj[i] < lo_q8) begin
                adj[i] = lo_q8;
            end
            if (adj[i] > hi_q8) begin
                adj[i] = hi_q8;
            end
            pwm[i] = motors_on_reg ? adj[i][15:8] : 8'd0;
        end
    end

    // Sticky running flag
    logic running_reg;
    logic running_next;

    assign running_next = motors_on_reg && (running_reg || fast_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            running_reg <= 1'b0;
        end else begin
            if (adv2) begin
                m_valid_reg <= v1_reg;
            end
            if (load2) begin
                running_reg <= running_next;
            end
        end
    end

    // Result register
    qxmm_out_t m_payload_reg;

    always_ff @(posedge aclk) begin
        if (load2) begin
            m_payload_reg.pwm_0      <= pwm[0];
            m_payload_reg.pwm_1      <= pwm[1];
            m_payload_reg.pwm_2      <= pwm[2];
            m_payload_reg.pwm_3      <= pwm[3];
            m_payload_reg.load_ratio <= load_ratio;
            m_payload_reg.overload   <= over;
            m_payload_reg.running    <= running_next;
        end
    end

    assign m_payload = m_payload_reg;

    // Checks
    `QXMM_ASSERT_SAME(a_running_matches, m_valid_reg, m_payload_reg.running == running_reg, "reported running flag differs from state")
    `QXMM_ASSERT_SAME(a_running_needs_on, $rose(running_reg), $past(motors_on_reg), "running flag set while motors off")
    `QXMM_ASSERT_SAME(a_result_from_stage1, $rose(m_valid_reg), $past(v1_reg), "result appeared without a stage 1 transaction")

endmodule
